// ----- rtl/bffa_pkg.sv -----
`timescale 1ns / 1ps
// Package: shared types, codes and constants of the block allocator.
package bffa_pkg;

  localparam int TOTAL_BLOCKS_DEF = 256;
  localparam int BLOCK_BYTES_DEF  = 32;
  localparam int HEADER_BYTES_DEF = 16;

  typedef enum logic [1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_QUERY = 2'd2,
    OP_CLEAR = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_SIZE = 2'd1,
    ST_NO_RUN   = 2'd2,
    ST_BAD_FREE = 2'd3
  } status_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic latch;      // capture the request
    logic scan_start; // reset the scan pointer and run counter
    logic scan_step;  // examine one map bit
    logic mark_start; // set up the mark or clear sweep
    logic mark_step;  // write one map bit
    logic clear_all;  // drop every map bit, head mark and the count
    logic free_head;  // set or drop the head mark and settle the count
    logic load_out;   // load the output register
    status_t status;  // status to load
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    opcode_t op;
    logic    size_bad;  // zero size or oversized request
    logic    free_bad;  // no head mark at the named block
    logic    found;     // run of the needed length found
    logic    scan_end;  // last map bit examined
    logic    mark_end;  // last bit of the sweep written
  } stat_t;

endpackage

// ----- rtl/bffa_datapath.sv -----
`timescale 1ns / 1ps
// Datapath: block map, head marks, run lengths, scan and sweep counters.
module bffa_datapath #(
  parameter int TOTAL_BLOCKS = bffa_pkg::TOTAL_BLOCKS_DEF,
  parameter int BLOCK_BYTES  = bffa_pkg::BLOCK_BYTES_DEF,
  parameter int HEADER_BYTES = bffa_pkg::HEADER_BYTES_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  bffa_pkg::cmd_t   cmd,
  output bffa_pkg::stat_t  stat,
  input  logic [25:0]      in_tdata,
  output logic [31:0]      out_tdata
);
  import bffa_pkg::*;

  localparam int IW = $clog2(TOTAL_BLOCKS);
  localparam int CW = IW + 1;
  localparam int NW = 18;
  localparam int SH = $clog2(BLOCK_BYTES);
  localparam int MW = NW + 1;
  localparam int KS = NW + SH;
  // Reciprocal of the block size, exact for every numerator below 2**NW.
  localparam longint unsigned RECIP =
    ((64'd1 << KS) + 64'(BLOCK_BYTES) - 64'd1) / 64'(BLOCK_BYTES);

  logic [TOTAL_BLOCKS-1:0] map_r;
  logic [TOTAL_BLOCKS-1:0] head_r;
  logic [CW-1:0]           len_mem [TOTAL_BLOCKS];
  logic [CW-1:0]           used_r;
  logic [1:0]              op_r;
  logic [16:0]             size_r;
  logic [7:0]              idx_r;
  logic [NW-1:0]           need_r, need_nxt;
  logic [CW-1:0]           ptr_r, cnt_r, first_r, mend_r;
  logic [CW-1:0]           len_rd_r;
  logic [CW-1:0]           freed_r;
  logic                    head_rd_r;
  logic [1:0]              out_st_r;
  logic [7:0]              out_start_r;
  logic [8:0]              out_run_r, out_used_r;
  logic [NW-1:0]           total;
  logic [NW+MW-1:0]        prod;
  logic [IW-1:0]           ptr_i;
  logic [IW-1:0]           in_idx;
  logic                    idx_ok;

  assign ptr_i  = ptr_r[IW-1:0];
  assign in_idx = IW'(in_tdata[25:18]);
  assign total  = NW'(in_tdata[17:2]) + NW'(HEADER_BYTES + BLOCK_BYTES - 1);
  assign idx_ok = (IW >= 8) || (in_tdata[25:18] < 8'(TOTAL_BLOCKS));

  // Blocks needed: multiply by the reciprocal of the block size and drop the fraction.
  always_comb begin
    prod     = (NW+MW)'(total) * (NW+MW)'(RECIP);
    need_nxt = NW'(prod >> KS);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_r      <= '0;
      head_r     <= '0;
      used_r     <= '0;
      op_r       <= '0;
    end else begin
      if (cmd.latch) begin
        op_r   <= in_tdata[1:0];
        size_r <= {1'b0, in_tdata[17:2]};
        idx_r  <= in_tdata[25:18];
        head_rd_r <= idx_ok && head_r[in_idx];
        need_r <= need_nxt;
      end
      if (cmd.scan_start) begin
        ptr_r <= '0;
        cnt_r <= '0;
      end else if (cmd.scan_step) begin
        if (map_r[ptr_i]) begin
          cnt_r <= '0;
        end else begin
          if (cnt_r == '0) first_r <= ptr_r;
          cnt_r <= cnt_r + 1'b1;
        end
        if (!(!map_r[ptr_i] && NW'(cnt_r) + 1'b1 == need_r)) ptr_r <= ptr_r + 1'b1;
      end
      if (cmd.mark_start) begin
        freed_r <= '0;
        if (op_r == OP_ALLOC) begin
          ptr_r  <= first_r;
          mend_r <= first_r + CW'(need_r);
        end else begin
          ptr_r  <= CW'(idx_r);
          mend_r <= (CW'(idx_r) + len_rd_r > CW'(TOTAL_BLOCKS)) ?
                    CW'(TOTAL_BLOCKS) : CW'(idx_r) + len_rd_r;
        end
      end else if (cmd.mark_step) begin
        if (op_r == OP_ALLOC) begin
          map_r[ptr_i] <= 1'b1;
        end else begin
          if (map_r[ptr_i]) freed_r <= freed_r + 1'b1;
          map_r[ptr_i] <= 1'b0;
        end
        ptr_r <= ptr_r + 1'b1;
      end
      if (cmd.free_head) begin
        if (op_r == OP_ALLOC) begin
          head_r[first_r[IW-1:0]] <= 1'b1;
          used_r <= used_r + CW'(need_r);
        end else begin
          head_r[IW'(idx_r)] <= 1'b0;
          used_r <= (used_r >= freed_r) ? used_r - freed_r : '0;
        end
      end
      if (cmd.clear_all) begin
        map_r  <= '0;
        head_r <= '0;
        used_r <= '0;
      end
    end
  end

  // Run-length store: written at the head of a new run, read at the freed head.
  always_ff @(posedge clk) begin
    if (cmd.free_head && op_r == OP_ALLOC) len_mem[first_r[IW-1:0]] <= CW'(need_r);
    if (cmd.latch) len_rd_r <= len_mem[in_idx];
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_st_r <= cmd.status;
      out_start_r <= '0;
      out_run_r   <= '0;
      out_used_r  <= 9'(used_r);
      if (cmd.status == ST_OK) begin
        case (op_r)
          OP_ALLOC: begin
            out_start_r <= 8'(first_r);
            out_run_r   <= 9'(need_r);
            out_used_r  <= 9'(used_r + CW'(need_r));
          end
          OP_FREE: begin
            out_start_r <= idx_r;
            out_run_r   <= 9'(len_rd_r);
            out_used_r  <= 9'((used_r >= freed_r) ? used_r - freed_r : '0);
          end
          OP_CLEAR: begin
            out_run_r  <= 9'(used_r);
            out_used_r <= '0;
          end
          default: ;
        endcase
      end
    end
  end

  assign out_tdata = {4'b0000, out_used_r, out_run_r, out_start_r, out_st_r};

  assign stat.op       = opcode_t'(op_r);
  assign stat.size_bad = size_r == '0 || need_r > NW'(TOTAL_BLOCKS);
  assign stat.free_bad = !head_rd_r;
  assign stat.found    = (cnt_r != '0) && NW'(cnt_r) == need_r;
  assign stat.scan_end = (ptr_r == CW'(TOTAL_BLOCKS));
  assign stat.mark_end = (ptr_r == mend_r);

endmodule

// ----- rtl/bffa_ctrl.sv -----
`timescale 1ns / 1ps
// Controller: sequences decode, first-fit scan, mark/clear sweep and result.
module bffa_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_fire,
  input  logic            out_busy,
  input  bffa_pkg::stat_t stat,
  output bffa_pkg::cmd_t  cmd,
  output logic            idle
);
  import bffa_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_DECODE = 7'b0000010,
    S_SCAN   = 7'b0000100,
    S_MSTART = 7'b0001000,
    S_MARK   = 7'b0010000,
    S_HEAD   = 7'b0100000,
    S_RESULT = 7'b1000000
  } state_t;

  state_t  state_r, state_nxt;
  status_t st_r, st_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      st_r    <= ST_OK;
    end else begin
      state_r <= state_nxt;
      st_r    <= st_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    st_nxt    = st_r;
    cmd       = '0;
    cmd.status = st_r;
    idle      = (state_r == S_IDLE);
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          cmd.latch = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        st_nxt = ST_OK;
        case (stat.op)
          OP_ALLOC: begin
            if (stat.size_bad) begin
              st_nxt    = ST_BAD_SIZE;
              state_nxt = S_RESULT;
            end else begin
              cmd.scan_start = 1'b1;
              state_nxt      = S_SCAN;
            end
          end
          OP_FREE: begin
            if (stat.free_bad) begin
              st_nxt    = ST_BAD_FREE;
              state_nxt = S_RESULT;
            end else begin
              state_nxt = S_MSTART;
            end
          end
          OP_QUERY: state_nxt = S_RESULT;
          default:  state_nxt = S_RESULT;
        endcase
      end
      S_SCAN: begin
        if (stat.found) begin
          state_nxt = S_MSTART;
        end else if (stat.scan_end) begin
          st_nxt    = ST_NO_RUN;
          state_nxt = S_RESULT;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      S_MSTART: begin
        cmd.mark_start = 1'b1;
        state_nxt      = S_MARK;
      end
      S_MARK: begin
        if (stat.mark_end) state_nxt = S_RESULT;
        else cmd.mark_step = 1'b1;
      end
      S_RESULT: begin
        if (!out_busy) begin
          cmd.load_out = 1'b1;
          if (stat.op == OP_CLEAR) cmd.clear_all = 1'b1;
          if (st_r == ST_OK && (stat.op == OP_ALLOC || stat.op == OP_FREE))
            cmd.free_head = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_HEAD:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

// ----- rtl/bitmap_first_fit_allocator_top.sv -----
`timescale 1ns / 1ps
// Top level: block allocator over a bitmap with first-fit search.
// The pool holds TOTAL_BLOCKS blocks of BLOCK_BYTES bytes. Each request is
// taken one at a time. An allocate adds HEADER_BYTES, rounds up to whole
// blocks and scans the map one block per cycle from block 0 for the first
// free run of that length, then marks the run one block per cycle. A free
// sweeps its run one block per cycle; query, clear and requests rejected
// at decode go straight to the result. The next request is taken once the
// controller is idle again. The one-bit-per-cycle scan and sweep set the
// rate. The block count comes from a multiply by the reciprocal of the
// block size, worked out when the request is taken. The result waits in
// an output register; a finished request holds in its last step while a
// result is still waiting there.
module bitmap_first_fit_allocator_top #(
  parameter int TOTAL_BLOCKS = bffa_pkg::TOTAL_BLOCKS_DEF,
  parameter int BLOCK_BYTES  = bffa_pkg::BLOCK_BYTES_DEF,
  parameter int HEADER_BYTES = bffa_pkg::HEADER_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // opcode[1:0], size_bytes[17:2], block_index[25:18]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata   // status[1:0], run_start[9:2], run_blocks[18:10],
                                  // blocks_in_use[27:19]
);
  import bffa_pkg::*;

  cmd_t  cmd;
  stat_t stat;
  logic  idle, out_valid_r, in_fire;

  assign in_fire   = in_tvalid && in_tready;
  assign in_tready = idle && rst_n;

  // Hold the result until it is taken on the output side.
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (cmd.load_out) out_valid_r <= 1'b1;
    else if (out_tready) out_valid_r <= 1'b0;
  end
  assign out_tvalid = out_valid_r;

  bffa_datapath #(
    .TOTAL_BLOCKS(TOTAL_BLOCKS),
    .BLOCK_BYTES (BLOCK_BYTES),
    .HEADER_BYTES(HEADER_BYTES)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .stat     (stat),
    .in_tdata (in_tdata[25:0]),
    .out_tdata(out_tdata)
  );

  bffa_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_fire (in_fire),
    .out_busy(out_valid_r && !out_tready),
    .stat    (stat),
    .cmd     (cmd),
    .idle    (idle)
  );

  // A result is only loaded while none is waiting.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> !(out_valid_r && !out_tready))
    else $error("result overwritten");

  // A request is only taken with the controller idle.
  a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |-> idle)
    else $error("request taken while busy");

  // After a clear the reported count is zero.
  a_clear_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.load_out && cmd.clear_all) |=> out_tdata[27:19] == 9'd0)
    else $error("clear left blocks in use");

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// Testbench: drives allocate, free, query and clear requests and checks every result.
module testbench;
  import bffa_pkg::*;

  localparam int NBLK    = TOTAL_BLOCKS_DEF;
  localparam int BBYTES  = BLOCK_BYTES_DEF;
  localparam int HBYTES  = HEADER_BYTES_DEF;
  localparam int WD_MAX  = 20000;

  typedef struct packed {
    opcode_t     op;
    logic [15:0] size;
    logic [7:0]  idx;
  } req_t;

  typedef struct packed {
    status_t    st;
    logic [7:0] start;
    logic [8:0] run;
    logic [8:0] used;
  } res_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;

  bitmap_first_fit_allocator_top DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  always #2 clk = ~clk;

  // Shadow allocator state
  logic       map_used [NBLK];
  logic       map_head [NBLK];
  logic [8:0] map_len  [NBLK];
  int         used_cnt;

  req_t pending_reqs[$];
  res_t expected_res[$];
  int   errors = 0;
  int   n_sent = 0, n_got = 0, n_alloc_ok = 0, n_free_ok = 0, n_full = 0;
  logic hold_off = 1'b0;
  int   live_heads[$];
  logic in_tready_seen = 1'b0;
  logic out_tvalid_seen = 1'b0;

  function automatic void shadow_clear();
    for (int i = 0; i < NBLK; i++) begin
      map_used[i] = 1'b0;
      map_head[i] = 1'b0;
      map_len[i] = '0;
    end
    used_cnt = 0;
  endfunction

  // Work out the result of one request and advance the shadow state.
  function automatic res_t allocator_predict(req_t r);
    res_t o;
    int need, cnt, first, prior;
    o = '{st: ST_OK, start: '0, run: '0, used: '0};
    case (r.op)
      OP_ALLOC: begin
        need = (int'(r.size) + HBYTES + BBYTES - 1) / BBYTES;
        if (r.size == 0 || need > NBLK) begin
          o.st = ST_BAD_SIZE;
        end else begin
          cnt = 0; first = 0;
          o.st = ST_NO_RUN;
          for (int i = 0; i < NBLK; i++) begin
            if (map_used[i]) begin
              cnt = 0;
            end else begin
              if (cnt == 0) first = i;
              cnt++;
              if (cnt == need) begin
                for (int b = first; b < first + need; b++) map_used[b] = 1'b1;
                map_head[first] = 1'b1;
                map_len[first] = 9'(need);
                used_cnt += need;
                o.st = ST_OK; o.start = 8'(first); o.run = 9'(need);
                break;
              end
            end
          end
        end
      end
      OP_FREE: begin
        if (!map_head[r.idx]) begin
          o.st = ST_BAD_FREE;
        end else begin
          cnt = 0;
          for (int b = r.idx; b < r.idx + map_len[r.idx] && b < NBLK; b++)
            if (map_used[b]) begin
              map_used[b] = 1'b0;
              cnt++;
            end
          map_head[r.idx] = 1'b0;
          used_cnt = (used_cnt >= cnt) ? used_cnt - cnt : 0;
          o.start = r.idx; o.run = map_len[r.idx];
        end
      end
      OP_QUERY: ;
      default: begin
        prior = used_cnt;
        shadow_clear();
        o.run = 9'(prior);
      end
    endcase
    o.used = 9'(used_cnt);
    return o;
  endfunction

  function automatic void push_req(opcode_t op, int size, int idx);
    req_t r;
    r.op = op; r.size = 16'(size); r.idx = 8'(idx);
    pending_reqs.push_back(r);
  endfunction

  // Pick a free target: mostly a live run start, sometimes any block.
  function automatic int pick_free_target();
    if (live_heads.size() > 0 && $urandom_range(0, 9) < 8)
      return live_heads[$urandom_range(0, live_heads.size() - 1)];
    return $urandom_range(0, 255);
  endfunction

  // Rough tracker of run starts so random frees mostly hit real heads.
  function automatic void track(req_t r, res_t o);
    if (r.op == OP_ALLOC && o.st == ST_OK) live_heads.push_back(o.start);
    if (r.op == OP_FREE && o.st == ST_OK)
      foreach (live_heads[i]) if (live_heads[i] == r.idx) begin
        live_heads.delete(i);
        break;
      end
    if (r.op == OP_CLEAR) live_heads.delete();
  endfunction

  // Driver: present each request after a random gap, hold until taken.
  int gap_in = 0;
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_tvalid || in_tready_seen) begin
        if (gap_in > 0) begin
          gap_in <= gap_in - 1;
          in_tvalid <= 1'b0;
        end else if (!hold_off && pending_reqs.size() > 0) begin
          in_tdata <= {6'd0, pending_reqs[0].idx, pending_reqs[0].size, pending_reqs[0].op};
          in_tvalid <= 1'b1;
          void'(pending_reqs.pop_front());
          gap_in <= $urandom_range(0, 13) * ($urandom_range(0, 3) != 0);
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Sample the input handshake at the rising edge and predict.
  always @(posedge clk) begin
    in_tready_seen <= rst_n && in_tvalid && in_tready;
    if (rst_n && in_tvalid && in_tready) begin
      req_t r;
      res_t o;
      r.op = opcode_t'(in_tdata[1:0]);
      r.size = in_tdata[17:2];
      r.idx = in_tdata[25:18];
      o = allocator_predict(r);
      track(r, o);
      if (r.op == OP_ALLOC && o.st == ST_OK) n_alloc_ok++;
      if (r.op == OP_FREE && o.st == ST_OK) n_free_ok++;
      if (o.st == ST_NO_RUN) n_full++;
      expected_res.push_back(o);
      n_sent++;
    end
  end

  // Monitor: random back-pressure, check each result against the oldest expectation.
  int gap_out = 0;
  always @(negedge clk) begin
    if (rst_n) begin
      if (gap_out > 0) begin
        gap_out <= gap_out - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        if (out_tready && out_tvalid_seen)
          gap_out <= $urandom_range(0, 13) * ($urandom_range(0, 2) != 0);
      end
    end
  end

  always @(posedge clk) begin
    out_tvalid_seen <= rst_n && out_tvalid && out_tready;
    if (rst_n && out_tvalid && out_tready) begin
      res_t got, want;
      got.st = status_t'(out_tdata[1:0]);
      got.start = out_tdata[9:2];
      got.run = out_tdata[18:10];
      got.used = out_tdata[27:19];
      n_got++;
      if (expected_res.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual %h", $realtime, out_tdata);
      end else begin
        want = expected_res.pop_front();
        if (got.st !== want.st) begin
          errors++;
          $display("%0t: status expected %0d actual %0d", $realtime, want.st, got.st);
        end
        if (got.start !== want.start) begin
          errors++;
          $display("%0t: run start expected %0d actual %0d", $realtime,
                   want.start, got.start);
        end
        if (got.run !== want.run) begin
          errors++;
          $display("%0t: run_blocks expected %0d actual %0d", $realtime, want.run, got.run);
        end
        if (got.used !== want.used) begin
          errors++;
          $display("%0t: blocks in use expected %0d actual %0d", $realtime,
                   want.used, got.used);
        end
      end
    end
  end

  // Watchdog: count cycles with no handshake on either side.
  int idle_cycles = 0;
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (rst_n) begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == WD_MAX) begin
        $display("watchdog: no progress for %0d cycles", WD_MAX);
        $display("FAIL");
        $finish;
      end
    end
  end

  // Stimulus: directed corners, then random sequences biased towards
  // allocate/free pairs with occasional clears and noise.
  initial begin
    int sz, k;
    shadow_clear();
    // Directed: zero size, smallest, block edges, full pool, oversize, maxima.
    push_req(OP_QUERY, 0, 0);
    push_req(OP_ALLOC, 0, 0);
    push_req(OP_ALLOC, 1, 0);
    push_req(OP_ALLOC, 16, 0);
    push_req(OP_ALLOC, 17, 0);
    push_req(OP_FREE, 1, 0);       // free of a run start
    push_req(OP_FREE, 1, 0);       // double free
    push_req(OP_FREE, 0, 3);       // free inside a run, no head mark
    push_req(OP_FREE, 0, 255);     // never allocated
    push_req(OP_ALLOC, 8176, 0);   // exactly the whole pool
    push_req(OP_ALLOC, 8177, 0);   // one byte too many
    push_req(OP_ALLOC, 65535, 255);
    push_req(OP_QUERY, 65535, 255);
    push_req(OP_CLEAR, 0, 0);
    push_req(OP_ALLOC, 8176, 0);   // whole pool
    push_req(OP_ALLOC, 1, 0);      // no free run
    push_req(OP_FREE, 0, 0);
    for (int i = 0; i < 4; i++) push_req(OP_ALLOC, 100, 0);
    push_req(OP_FREE, 0, 4);       // hole in the middle
    push_req(OP_ALLOC, 60, 0);     // fits the hole
    push_req(OP_CLEAR, 65535, 255);
    push_req(OP_CLEAR, 0, 0);

    repeat (9) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // Pause the sender until the directed part has fully drained.
    wait (pending_reqs.size() == 0 && !in_tvalid);
    hold_off = 1'b1;
    wait (expected_res.size() == 0);
    @(negedge clk) hold_off = 1'b0;

    for (int n = 0; n < 1930; n++) begin
      k = $urandom_range(0, 99);
      if (k < 45) begin
        // mostly small sizes, a few large ones
        case ($urandom_range(0, 9))
          0: sz = $urandom_range(0, 65535);
          1: sz = $urandom_range(1000, 8200);
          default: sz = $urandom_range(1, 300);
        endcase
        push_req(OP_ALLOC, sz, $urandom_range(0, 255));
      end else if (k < 85) begin
        push_req(OP_FREE, $urandom_range(0, 65535), 0);
        pending_reqs[$].idx = 8'(pick_free_target());
      end else if (k < 95) begin
        push_req(OP_QUERY, $urandom_range(0, 65535), $urandom_range(0, 255));
      end else begin
        push_req(OP_CLEAR, $urandom_range(0, 65535), $urandom_range(0, 255));
      end
      // keep the queue shallow so frees target current runs
      wait (pending_reqs.size() < 2);
    end
    wait (pending_reqs.size() == 0 && !in_tvalid);
    wait (expected_res.size() == 0);
    repeat (2 * NBLK + 20) @(posedge clk);
    $display("Covered %0d requests: %0d allocations, %0d frees, %0d full-pool misses.",
             n_sent, n_alloc_ok, n_free_ok, n_full);
    $display("%0d results checked against the shadow allocator.", n_got);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/bffa_pkg.sv
rtl/bffa_datapath.sv
rtl/bffa_ctrl.sv
rtl/bitmap_first_fit_allocator_top.sv
tb/testbench.sv
